>>> hdl/assert_macros.svh
// assertion macros shared by the coin change way counter rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define CCHG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked check that a condition never holds
`define CCHG_NEVER(name, cond, msg) \
  `CCHG_ASSERT(name, !(cond), msg)

`endif

>>> hdl/cchg_pkg.sv
// package for the coin change way counter: field widths, register map,
// reset values and the control struct between sequencer and adder unit
// no dependencies
package cchg_pkg;

  // fixed field widths
  localparam int unsigned AMOUNT_W       = 12;
  localparam int unsigned DENOM_W        = 12;
  localparam int unsigned IN_USE_W       = 3;
  localparam int unsigned NUM_DENOM_REGS = 4;
  localparam int unsigned DIDX_W         = 2;
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned PADDR_W        = 5;
  // wide enough for any amount or table address
  localparam int unsigned WIDE_W         = 17;

  // parameter defaults
  localparam int unsigned MAX_AMOUNT_DEF  = 4095;
  localparam int unsigned MAX_DENOMS_DEF  = 4;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // register map, word index
  typedef enum logic [IN_USE_W-1:0] {
    REG_DENOM_0 = 3'd0,
    REG_DENOM_1 = 3'd1,
    REG_DENOM_2 = 3'd2,
    REG_DENOM_3 = 3'd3,
    REG_IN_USE  = 3'd4
  } cchg_reg_e;

  // register reset values
  localparam logic [NUM_DENOM_REGS-1:0][DENOM_W-1:0] DENOM_RST =
    {12'd50, 12'd10, 12'd5, 12'd1};
  localparam logic [IN_USE_W-1:0] IN_USE_RST = 3'd4;

  // per-cycle command from the sequencer
  typedef struct packed {
    logic clr;      // write clear value at the x address
    logic clr_one;  // clear value is one (table entry zero)
    logic upd;      // issue reads for one table update
    logic rd;       // issue the final read of the answer
  } cchg_ctl_t;

endpackage

>>> hdl/coin_change_way_count.sv
// top level of the coin change way counter: register port, handshakes,
// result register; depends on cchg_pkg, cchg_seq, cchg_acc, cchg_ram
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+--------------------------
//  input    | in        | in_valid_i / in_ready_o  | amount_i
//  result   | out       | out_valid_o / out_ready_i| way_count_o, overflow_o
//  config   | in        | psel, penable, pwrite    | paddr, pwdata, prdata
//
// an amount A within range runs a clear sweep of entries 0 to A, and for each
// used coin d with 0 < d <= A a pass over entries d to A, and a final read;
// the single table write port updates one entry per cycle in sweep and passes
// an amount above MAX_AMOUNT skips the table and returns a zero count
// reset clears control and loads register defaults; the table is not cleared
// a held result stalls only the end of the next item, not its transfer in
`include "assert_macros.svh"

module coin_change_way_count #(
  parameter int unsigned MAX_AMOUNT  = cchg_pkg::MAX_AMOUNT_DEF,
  parameter int unsigned MAX_DENOMS  = cchg_pkg::MAX_DENOMS_DEF,
  parameter int unsigned COUNT_WIDTH = cchg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cchg_pkg::PADDR_W-1:0]     paddr,
  input  logic [cchg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cchg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cchg_pkg::AMOUNT_W-1:0]    amount_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cchg_pkg::OUT_W-1:0]       way_count_o,
  output logic                             overflow_o
);
  import cchg_pkg::*;

  localparam int unsigned DEPTH  = MAX_AMOUNT + 1;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [NUM_DENOM_REGS-1:0][DENOM_W-1:0] denom_q;
  logic [IN_USE_W-1:0]                    in_use_q;
  logic                                   cfg_wr;
  cchg_reg_e                              cfg_idx;

  logic                     seq_idle;
  logic                     seq_result;
  logic                     zero_res;
  cchg_ctl_t                ctl;
  logic [ADDR_W-1:0]        xa;
  logic [ADDR_W-1:0]        ya;
  logic [COUNT_WIDTH:0]     rd_x;
  logic [COUNT_WIDTH:0]     rd_y;
  logic                     we;
  logic [ADDR_W-1:0]        wa;
  logic [COUNT_WIDTH:0]     wd;
  logic [COUNT_WIDTH:0]     x_val;
  logic                     in_xfer;
  logic                     out_free;
  logic                     out_load;
  logic [OUT_W+COUNT_WIDTH-1:0] cnt_ext;

  logic                     out_valid_q, out_valid_d;
  logic [OUT_W-1:0]         way_count_q, way_count_d;
  logic                     overflow_q, overflow_d;

  // register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cchg_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      denom_q  <= DENOM_RST;
      in_use_q <= IN_USE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DENOM_0: denom_q[0] <= pwdata[DENOM_W-1:0];
        REG_DENOM_1: denom_q[1] <= pwdata[DENOM_W-1:0];
        REG_DENOM_2: denom_q[2] <= pwdata[DENOM_W-1:0];
        REG_DENOM_3: denom_q[3] <= pwdata[DENOM_W-1:0];
        REG_IN_USE:  in_use_q   <= pwdata[IN_USE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_DENOM_0: prdata = APB_DATA_W'(denom_q[0]);
      REG_DENOM_1: prdata = APB_DATA_W'(denom_q[1]);
      REG_DENOM_2: prdata = APB_DATA_W'(denom_q[2]);
      REG_DENOM_3: prdata = APB_DATA_W'(denom_q[3]);
      REG_IN_USE:  prdata = APB_DATA_W'(in_use_q);
      default:     prdata = '0;
    endcase
  end

  // handshakes
  assign in_ready_o = seq_idle;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = seq_result && out_free;

  cchg_seq #(
    .MAX_AMOUNT (MAX_AMOUNT),
    .MAX_DENOMS (MAX_DENOMS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .amount_i   (amount_i),
    .denoms_i   (denom_q),
    .in_use_i   (in_use_q),
    .out_free_i (out_free),
    .idle_o     (seq_idle),
    .result_o   (seq_result),
    .zero_res_o (zero_res),
    .ctl_o      (ctl),
    .xa_o       (xa),
    .ya_o       (ya)
  );

  cchg_acc #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .xa_i    (xa),
    .ya_i    (ya),
    .rd_x_i  (rd_x),
    .rd_y_i  (rd_y),
    .we_o    (we),
    .wa_o    (wa),
    .wd_o    (wd),
    .x_val_o (x_val)
  );

  cchg_ram #(
    .WIDTH (COUNT_WIDTH + 1),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (wa),
    .wdata_i   (wd),
    .re_i      (ctl.upd || ctl.rd),
    .raddr_a_i (xa),
    .raddr_b_i (ya),
    .rdata_a_o (rd_x),
    .rdata_b_o (rd_y)
  );

  // result register, low bits of the count
  assign cnt_ext     = {{OUT_W{1'b0}}, x_val[COUNT_WIDTH-1:0]};
  assign way_count_d = zero_res ? '0 : cnt_ext[OUT_W-1:0];
  assign overflow_d  = zero_res ? 1'b0 : x_val[COUNT_WIDTH];

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      way_count_q <= way_count_d;
      overflow_q  <= overflow_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign way_count_o = way_count_q;
  assign overflow_o  = overflow_q;

  `CCHG_NEVER(top_load_while_idle, in_ready_o && out_load, "result loaded while idle")
  `CCHG_ASSERT(top_busy_after_xfer, in_xfer |=> !in_ready_o, "second transfer taken while busy")

endmodule

>>> hdl/cchg_ram.sv
// generic table memory: one write port, two read ports, registered reads
// no dependencies
module cchg_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  // write port and registered reads, read data holds while idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

>>> hdl/cchg_acc.sv
// shared saturating adder with write forwarding for the way table
// depends on cchg_pkg and assert_macros.svh
`include "assert_macros.svh"

module cchg_acc #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned ADDR_W      = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cchg_pkg::cchg_ctl_t   ctl_i,
  input  logic [ADDR_W-1:0]     xa_i,
  input  logic [ADDR_W-1:0]     ya_i,
  input  logic [COUNT_WIDTH:0]  rd_x_i,
  input  logic [COUNT_WIDTH:0]  rd_y_i,
  output logic                  we_o,
  output logic [ADDR_W-1:0]     wa_o,
  output logic [COUNT_WIDTH:0]  wd_o,
  output logic [COUNT_WIDTH:0]  x_val_o
);
  import cchg_pkg::*;

  logic                 upd_q;
  logic [ADDR_W-1:0]    xa_q;
  logic [ADDR_W-1:0]    ya_q;
  logic                 fwd_vld_q;
  logic [ADDR_W-1:0]    fwd_a_q;
  logic [COUNT_WIDTH:0] fwd_d_q;
  logic [COUNT_WIDTH:0] x_sel;
  logic [COUNT_WIDTH:0] y_sel;
  logic [COUNT_WIDTH:0] sum;
  logic                 sat;
  logic [COUNT_WIDTH:0] upd_wd;

  // read data is stale when the same entry was written on the read edge
  assign x_sel = (fwd_vld_q && (fwd_a_q == xa_q)) ? fwd_d_q : rd_x_i;
  assign y_sel = (fwd_vld_q && (fwd_a_q == ya_q)) ? fwd_d_q : rd_y_i;

  // saturating add, flag is sticky through every sum
  assign sum    = {1'b0, x_sel[COUNT_WIDTH-1:0]} + {1'b0, y_sel[COUNT_WIDTH-1:0]};
  assign sat    = x_sel[COUNT_WIDTH] | y_sel[COUNT_WIDTH] | sum[COUNT_WIDTH];
  assign upd_wd = {sat, sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0]};

  // write port: clear sweep or update result
  always_comb begin
    we_o = 1'b0;
    wa_o = xa_q;
    wd_o = upd_wd;
    if (ctl_i.clr) begin
      we_o = 1'b1;
      wa_o = xa_i;
      wd_o = (COUNT_WIDTH + 1)'(ctl_i.clr_one);
    end else if (upd_q) begin
      we_o = 1'b1;
    end
  end

  assign x_val_o = x_sel;

  // update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q     <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      upd_q     <= ctl_i.upd;
      fwd_vld_q <= we_o;
    end
  end

  // addresses of the reads in flight and the last write
  always_ff @(posedge clk_i) begin
    if (ctl_i.upd || ctl_i.rd) begin
      xa_q <= xa_i;
      ya_q <= ya_i;
    end
    fwd_a_q <= wa_o;
    fwd_d_q <= wd_o;
  end

  `CCHG_NEVER(acc_no_write_clash, ctl_i.clr && upd_q, "clear and update write in one cycle")
  `CCHG_ASSERT(acc_flag_sticky, upd_q && (x_sel[COUNT_WIDTH] || y_sel[COUNT_WIDTH]) |-> wd_o[COUNT_WIDTH], "saturation flag lost in update")

endmodule

>>> hdl/cchg_seq.sv
// sequencer for the coin change way counter: clear sweep, a pass per coin d
// used, from d to the amount, final read; needs cchg_pkg, assert_macros.svh
`include "assert_macros.svh"

module cchg_seq #(
  parameter int unsigned MAX_AMOUNT = 4095,
  parameter int unsigned MAX_DENOMS = 4,
  localparam int unsigned ADDR_W = $clog2(MAX_AMOUNT + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cchg_pkg::AMOUNT_W-1:0] amount_i,
  input  logic [cchg_pkg::NUM_DENOM_REGS-1:0][cchg_pkg::DENOM_W-1:0] denoms_i,
  input  logic [cchg_pkg::IN_USE_W-1:0] in_use_i,
  input  logic                       out_free_i,
  output logic                       idle_o,
  output logic                       result_o,
  output logic                       zero_res_o,
  output cchg_pkg::cchg_ctl_t        ctl_o,
  output logic [ADDR_W-1:0]          xa_o,
  output logic [ADDR_W-1:0]          ya_o
);
  import cchg_pkg::*;

  localparam int unsigned CAP =
    (MAX_DENOMS < NUM_DENOM_REGS) ? MAX_DENOMS : NUM_DENOM_REGS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_SELECT = 6'b000100,
    S_PASS   = 6'b001000,
    S_READ   = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [IN_USE_W-1:0] k_q, k_d;
  logic                big_q, big_d;
  logic [ADDR_W-1:0]   a_q, a_d;
  logic [ADDR_W-1:0]   amt_q, amt_d;
  logic [ADDR_W-1:0]   d_q, d_d;
  logic [IN_USE_W-1:0] used;
  logic [DENOM_W-1:0]  den_sel;
  logic [WIDE_W-1:0]   amt_wide;
  logic [WIDE_W-1:0]   den_wide;
  logic [WIDE_W-1:0]   amtq_wide;

  // denominations taken, capped by register count and parameter
  assign used      = (in_use_i > IN_USE_W'(CAP)) ? IN_USE_W'(CAP) : in_use_i;
  assign den_sel   = denoms_i[k_q[DIDX_W-1:0]];
  assign amt_wide  = WIDE_W'(amount_i);
  assign den_wide  = WIDE_W'(den_sel);
  assign amtq_wide = WIDE_W'(amt_q);

  // next state and table commands
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    big_d   = big_q;
    a_d     = a_q;
    amt_d   = amt_q;
    d_d     = d_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (amt_wide > WIDE_W'(MAX_AMOUNT)) begin
            big_d   = 1'b1;
            state_d = S_RESULT;
          end else begin
            big_d   = 1'b0;
            amt_d   = amt_wide[ADDR_W-1:0];
            a_d     = '0;
            state_d = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        ctl_o.clr     = 1'b1;
        ctl_o.clr_one = (a_q == '0);
        if (a_q == amt_q) begin
          k_d     = '0;
          state_d = S_SELECT;
        end else begin
          a_d = a_q + ADDR_W'(1);
        end
      end
      S_SELECT: begin
        if (k_q >= used) begin
          state_d = S_READ;
        end else if ((den_sel == '0) || (den_wide > amtq_wide)) begin
          k_d = k_q + IN_USE_W'(1);
        end else begin
          d_d     = den_wide[ADDR_W-1:0];
          a_d     = den_wide[ADDR_W-1:0];
          state_d = S_PASS;
        end
      end
      S_PASS: begin
        ctl_o.upd = 1'b1;
        if (a_q == amt_q) begin
          k_d     = k_q + IN_USE_W'(1);
          state_d = S_SELECT;
        end else begin
          a_d = a_q + ADDR_W'(1);
        end
      end
      S_READ: begin
        ctl_o.rd = 1'b1;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // table addresses: x is the entry updated or read out, y lags by one coin
  assign xa_o       = (state_q == S_READ) ? amt_q : a_q;
  assign ya_o       = a_q - d_q;
  assign idle_o     = (state_q == S_IDLE);
  assign result_o   = (state_q == S_RESULT);
  assign zero_res_o = big_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      big_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      big_q   <= big_d;
    end
  end

  // sweep position, amount and current coin
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    amt_q <= amt_d;
    d_q   <= d_d;
  end

  `CCHG_ASSERT(seq_pass_range, state_q == S_PASS |-> (a_q >= d_q && a_q <= amt_q), "pass address out of range")

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for coin_change_way_count: directed and random amounts
// checked against a bottom-up way-table predictor; depends on cchg_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import cchg_pkg::*;

  localparam int unsigned MAX_AMOUNT  = MAX_AMOUNT_DEF;
  localparam int unsigned MAX_DENOMS  = MAX_DENOMS_DEF;
  localparam int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF;
  localparam bit [63:0]   COUNT_MAX   = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam int unsigned CYCLE_LIMIT = 12_000_000;
  localparam int unsigned TAIL_CYCLES = 100;

  typedef struct packed {
    bit [OUT_W-1:0] count;
    bit             ovf;
  } way_res_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [PADDR_W-1:0]    paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [AMOUNT_W-1:0]   amount_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OUT_W-1:0]      way_count_o;
  logic                  overflow_o;

  // register mirror, way table and expected counts
  bit [DENOM_W-1:0]  denom_cfg [NUM_DENOM_REGS];
  bit [IN_USE_W-1:0] in_use_cfg;
  bit [63:0]         way_val  [0:MAX_AMOUNT];
  bit                way_flag [0:MAX_AMOUNT];
  way_res_t          pending_ways [$];
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  bit                idle_on = 1'b0;

  coin_change_way_count dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .amount_i    (amount_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .way_count_o (way_count_o),
    .overflow_o  (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // count ways bottom-up with saturation and a sticky flag
  function automatic way_res_t count_ways(input bit [AMOUNT_W-1:0] amt);
    way_res_t    res;
    int unsigned used;
    int unsigned d;
    bit [63:0]   s;
    bit          f;
    res = '0;
    if (int'(amt) > int'(MAX_AMOUNT)) return res;
    used = in_use_cfg;
    if (used > NUM_DENOM_REGS) used = NUM_DENOM_REGS;
    if (used > MAX_DENOMS) used = MAX_DENOMS;
    way_val[0]  = 64'd1;
    way_flag[0] = 1'b0;
    for (int a = 1; a <= int'(amt); a++) begin
      way_val[a]  = '0;
      way_flag[a] = 1'b0;
    end
    for (int k = 0; k < int'(used); k++) begin
      d = denom_cfg[k];
      if (d != 0) begin
        for (int a = d; a <= int'(amt); a++) begin
          s = way_val[a] + way_val[a-d];
          f = way_flag[a] | way_flag[a-d];
          if ((s < way_val[a]) || (s > COUNT_MAX)) begin
            s = COUNT_MAX;
            f = 1'b1;
          end
          way_val[a]  = s;
          way_flag[a] = f;
        end
      end
    end
    res.count = way_val[amt][OUT_W-1:0];
    res.ovf   = way_flag[amt];
    return res;
  endfunction

  // no gaps while idle_on is off, else mostly short gaps and a few long ones
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 80);
  endfunction

  // mostly small amounts, a few up to the largest
  function automatic bit [AMOUNT_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return AMOUNT_W'($urandom_range(0, 255));
    if (r < 95) return AMOUNT_W'($urandom_range(256, 1023));
    return AMOUNT_W'($urandom_range(0, MAX_AMOUNT));
  endfunction

  function automatic bit [DENOM_W-1:0] pick_denom();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return DENOM_W'($urandom_range(1, 4095));
    return DENOM_W'($urandom_range(1, 12));
  endfunction

  // register read with compare against the mirror
  task automatic reg_read_check(input cchg_reg_e idx);
    bit [APB_DATA_W-1:0] want;
    want = (idx == REG_IN_USE) ? APB_DATA_W'(in_use_cfg) : APB_DATA_W'(denom_cfg[idx]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %s read: expected %0d, actual %0d", $time, idx.name(), want,
               prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write, mirror update, then read back
  task automatic reg_write(input cchg_reg_e idx, input bit [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_IN_USE) in_use_cfg = data[IN_USE_W-1:0];
    else denom_cfg[idx] = data[DENOM_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    reg_read_check(idx);
  endtask

  task automatic set_coins(input bit [DENOM_W-1:0] d0, input bit [DENOM_W-1:0] d1,
                           input bit [DENOM_W-1:0] d2, input bit [DENOM_W-1:0] d3,
                           input bit [IN_USE_W-1:0] used);
    reg_write(REG_DENOM_0, APB_DATA_W'(d0));
    reg_write(REG_DENOM_1, APB_DATA_W'(d1));
    reg_write(REG_DENOM_2, APB_DATA_W'(d2));
    reg_write(REG_DENOM_3, APB_DATA_W'(d3));
    reg_write(REG_IN_USE, APB_DATA_W'(used));
  endtask

  // one amount transfer; valid stays high into the next call when there is no gap
  task automatic send_amount(input bit [AMOUNT_W-1:0] amt);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    amount_i   <= amt;
    do @(posedge clk_i); while (!in_ready_o);
    pending_ways.push_back(count_ways(amt));
  endtask

  // stop sending and wait for every pending count
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_ways.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 3))
          @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // compare each result transfer with the oldest pending count
  always @(posedge clk_i) begin
    way_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ways.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual way_count %0d overflow %0d",
                 $time, way_count_o, overflow_o);
        fail_count++;
      end else begin
        want = pending_ways.pop_front();
        if (way_count_o !== want.count) begin
          $display("%0t: way_count: expected %0d, actual %0d", $time, want.count,
                   way_count_o);
          fail_count++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow: expected %0d, actual %0d", $time, want.ovf, overflow_o);
          fail_count++;
        end
      end
    end
  end

  // reset register values, then amounts with the default coins
  task automatic test_reset_defaults();
    idle_on = 1'b0;
    for (int i = 0; i <= int'(REG_IN_USE); i++) reg_read_check(cchg_reg_e'(i));
    send_amount(12'd0);
    send_amount(12'd1);
    send_amount(12'd100);
    send_amount(12'hAAA);
    send_amount(12'h555);
    send_amount(12'hFFF);
    drain_results();
  endtask

  // no coins, zero coins skipped, too many coins capped, largest coin
  task automatic test_special_denoms();
    idle_on = 1'b1;
    set_coins(12'd1, 12'd5, 12'd10, 12'd50, 3'd0);
    send_amount(12'd0);
    send_amount(12'd5);
    drain_results();
    set_coins(12'd0, 12'd2, 12'd0, 12'd3, 3'd2);
    send_amount(12'd10);
    send_amount(12'd11);
    drain_results();
    set_coins(12'd3, 12'd0, 12'd7, 12'd4095, 3'd7);
    send_amount(12'd21);
    send_amount(12'd4095);
    drain_results();
    set_coins(12'd4095, 12'd1, 12'd1, 12'd1, 3'd1);
    send_amount(12'd4094);
    send_amount(12'd4095);
    drain_results();
  endtask

  // four one-unit coins saturate just above 2951
  task automatic test_saturation();
    set_coins(12'd1, 12'd1, 12'd1, 12'd1, 3'd4);
    send_amount(12'd2951);
    send_amount(12'd2952);
    send_amount(12'd4095);
    drain_results();
    reg_write(REG_IN_USE, APB_DATA_W'(3'd3));
    send_amount(12'd4095);
    drain_results();
  endtask

  // random coin settings, each phase drained before the next setting
  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      idle_on = (ph != 0);
      set_coins(pick_denom(), pick_denom(), pick_denom(), pick_denom(),
                ($urandom_range(0, 1) == 0) ? 3'd4 : IN_USE_W'($urandom_range(0, 7)));
      for (int n = 0; n < 20; n++) send_amount(pick_amount());
      drain_results();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_DENOM_REGS; i++) denom_cfg[i] = DENOM_RST[i];
    in_use_cfg = IN_USE_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_special_denoms();
    test_saturation();
    test_random_traffic();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
